FILE: sv/scsc_pkg.sv
// Shared types, codes and helper functions of the sparse circular separable convolution.
package scsc_pkg;

  localparam int MAX_AXIS_LEN_DEF = 64;
  localparam int MAX_POINTS_DEF   = 1024;

  localparam int SIZE_W  = 7;
  localparam int COORD_W = 6;
  localparam int VAL_W   = 24;
  localparam int KVAL_W  = 16;
  localparam int TIDX_W  = 6;
  localparam int PNUM_W  = 10;
  localparam int SUM_W   = 40;
  localparam int LIN_W   = 24;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 64;
  localparam int FRAC_BITS  = 14;

  localparam logic [63:0] SUM_MAX = 64'h0000_007F_FFFF_FFFF;
  localparam logic [63:0] SUM_MIN = 64'hFFFF_FF80_0000_0000;

  localparam logic [1:0] CMD_KLOAD = 2'd0;
  localparam logic [1:0] CMD_PLOAD = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_EVAL  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOTSTOR = 2'd2;
  localparam logic [1:0] ST_BEYOND  = 2'd3;

  localparam logic [2:0] K_KLOAD  = 3'd0;
  localparam logic [2:0] K_PLOAD  = 3'd1;
  localparam logic [2:0] K_CLEAR  = 3'd2;
  localparam logic [2:0] K_EVAL   = 3'd3;
  localparam logic [2:0] K_BEYOND = 3'd4;
  localparam logic [2:0] K_NOP    = 3'd5;

  typedef logic [3:0][SIZE_W-1:0] sizes_t;

  typedef struct packed {
    logic [VAL_W-1:0]        val;
    logic [3:0][COORD_W-1:0] c;
  } point_t;

  typedef struct packed {
    logic [2:0]              kind;
    logic [1:0]              axis;
    logic [TIDX_W-1:0]       table_index;
    logic [KVAL_W-1:0]       kernel_value;
    point_t                  pt;
    logic [PNUM_W-1:0]       point_number;
  } cmd_t;

  // Q2.14 product, truncated and saturated to 16 bits.
  function automatic logic [KVAL_W-1:0] qmul(input logic [KVAL_W-1:0] a,
                                             input logic [KVAL_W-1:0] b);
    logic [31:0] p;
    p = (32'(a) * 32'(b)) >> FRAC_BITS;
    return (p > 32'h0000_FFFF) ? 16'hFFFF : p[KVAL_W-1:0];
  endfunction

endpackage

FILE: sv/scsc_front.sv
// Front end: unpacks an input word and classifies the command.
module scsc_front #(
  parameter int MAX_AXIS_LEN = scsc_pkg::MAX_AXIS_LEN_DEF
) (
  input  logic [scsc_pkg::IN_DATA_W-1:0] tdata,
  input  logic [1:0]                     tuser,
  input  scsc_pkg::sizes_t               sizes,
  output scsc_pkg::cmd_t                 cmd
);
  localparam int TAB_LEN = MAX_AXIS_LEN / 2 + 1;

  logic beyond;

  always_comb begin
    cmd.axis         = tdata[1:0];
    cmd.table_index  = tdata[7:2];
    cmd.kernel_value = tdata[23:8];
    cmd.pt.c[0]      = tdata[29:24];
    cmd.pt.c[1]      = tdata[35:30];
    cmd.pt.c[2]      = tdata[41:36];
    cmd.pt.c[3]      = tdata[47:42];
    cmd.pt.val       = tdata[71:48];
    cmd.point_number = tdata[81:72];
    beyond = 1'b0;
    for (int a = 0; a < 4; a++) begin
      if ({1'b0, cmd.pt.c[a]} >= sizes[a]) beyond = 1'b1;
    end
    case (tuser)
      scsc_pkg::CMD_KLOAD: begin
        cmd.kind = (32'(cmd.table_index) >= TAB_LEN) ? scsc_pkg::K_BEYOND : scsc_pkg::K_KLOAD;
      end
      scsc_pkg::CMD_PLOAD: begin
        if (beyond) cmd.kind = scsc_pkg::K_BEYOND;
        else if (cmd.pt.val == '0) cmd.kind = scsc_pkg::K_NOP;
        else cmd.kind = scsc_pkg::K_PLOAD;
      end
      scsc_pkg::CMD_CLEAR: cmd.kind = scsc_pkg::K_CLEAR;
      default: cmd.kind = scsc_pkg::K_EVAL;
    endcase
  end
endmodule

FILE: sv/scsc_queue.sv
// Two-entry command queue between the front end and the engine.
module scsc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  scsc_pkg::cmd_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output scsc_pkg::cmd_t out_data
);
  scsc_pkg::cmd_t slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = slots[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= in_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

FILE: sv/scsc_back.sv
// Engine: kernel tables, point store and the evaluation multiply-accumulate pipeline.
module scsc_back #(
  parameter int MAX_AXIS_LEN = scsc_pkg::MAX_AXIS_LEN_DEF,
  parameter int MAX_POINTS   = scsc_pkg::MAX_POINTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  scsc_pkg::sizes_t                sizes,
  input  logic                            q_valid,
  output logic                            q_ready,
  input  scsc_pkg::cmd_t                  q_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_status,
  output logic [scsc_pkg::SUM_W-1:0]      out_sum,
  output logic [scsc_pkg::LIN_W-1:0]      out_lin
);
  localparam int TAB_LEN = MAX_AXIS_LEN / 2 + 1;
  localparam int TI_W    = $clog2(TAB_LEN);
  localparam int PA_W    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int ACC_W   = 41 + CNT_W;
  localparam int KW      = scsc_pkg::KVAL_W;
  localparam int CW      = scsc_pkg::COORD_W;
  localparam int SW      = scsc_pkg::SIZE_W;

  localparam logic signed [ACC_W-1:0] SMAX = ACC_W'(scsc_pkg::SUM_MAX);
  localparam logic signed [ACC_W-1:0] SMIN = ACC_W'(scsc_pkg::SUM_MIN);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RDO  = 4'd1;
  localparam logic [3:0] S_LIN1 = 4'd2;
  localparam logic [3:0] S_LIN2 = 4'd3;
  localparam logic [3:0] S_LIN3 = 4'd4;
  localparam logic [3:0] S_LOOP = 4'd5;
  localparam logic [3:0] S_FIN  = 4'd6;

  logic [3:0]       state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] n;

  // Point store.
  scsc_pkg::point_t pmem [MAX_POINTS];
  scsc_pkg::point_t pt_rd;
  logic [PA_W-1:0]  rd_addr;
  logic             pt_we;

  // Kernel tables, one memory per axis with valid bits cleared by reset.
  logic [3:0][KW-1:0]      kq;
  logic [3:0]              kvq;
  logic [3:0][TI_W-1:0]    kra;
  logic [3:0][TAB_LEN-1:0] kvalid;
  logic                    kwe;
  logic [TI_W-1:0]         kwa;

  // Evaluated point and linear index pieces.
  logic [3:0][CW-1:0] o_c;
  logic [13:0]        s01;
  logic [20:0]        s012;
  logic [12:0]        la;
  logic [19:0]        lb;
  logic [26:0]        lc;

  // Pipeline.
  logic             issue;
  logic [5:0]       pv;
  logic             s1_stale, s2_stale, s3_stale;
  logic [23:0]      s1_val, s2_val, s3_val, s4_val;
  logic [KW-1:0]    s2_p, s2_k2, s2_k3, s3_p, s3_k3, s4_p;
  logic signed [40:0] s5_term;
  logic signed [ACC_W-1:0] acc, acc_sh;
  logic             stale_c;
  logic [3:0][KW-1:0] keff;

  assign q_ready = (state == S_IDLE) && !out_valid;
  assign issue   = (state == S_LOOP) && (n < count);
  assign rd_addr = (state == S_LOOP) ? n[PA_W-1:0] : PA_W'(q_data.point_number);
  assign pt_we   = q_valid && q_ready && (q_data.kind == scsc_pkg::K_PLOAD)
                   && (32'(count) < MAX_POINTS);
  assign kwe     = q_valid && q_ready && (q_data.kind == scsc_pkg::K_KLOAD);
  assign kwa     = TI_W'(q_data.table_index);

  always_ff @(posedge clk) begin
    if (pt_we) pmem[count[PA_W-1:0]] <= q_data.pt;
    pt_rd <= pmem[rd_addr];
  end

  // Circular distance per axis for the point coming out of the store.
  always_comb begin
    logic [CW-1:0] d;
    logic [SW-1:0] d7;
    stale_c = 1'b0;
    for (int a = 0; a < 4; a++) begin
      if ({1'b0, pt_rd.c[a]} >= sizes[a]) stale_c = 1'b1;
      d  = (o_c[a] > pt_rd.c[a]) ? o_c[a] - pt_rd.c[a] : pt_rd.c[a] - o_c[a];
      d7 = ({1'b0, d} > (sizes[a] >> 1)) ? sizes[a] - {1'b0, d} : {1'b0, d};
      kra[a] = (32'(d7) >= TAB_LEN) ? TI_W'(TAB_LEN - 1) : TI_W'(d7);
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_ktab
    logic [KW-1:0] kmem [TAB_LEN];
    always_ff @(posedge clk) begin
      if (kwe && q_data.axis == 2'(g)) kmem[kwa] <= q_data.kernel_value;
      kq[g] <= kmem[kra[g]];
    end
    assign keff[g] = kvq[g] ? kq[g] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kvalid <= '0;
      kvq    <= '0;
    end else begin
      if (kwe) kvalid[q_data.axis][kwa] <= 1'b1;
      for (int a = 0; a < 4; a++) kvq[a] <= kvalid[a][kra[a]];
    end
  end

  // Pipeline data path.
  always_ff @(posedge clk) begin
    s1_stale <= stale_c;
    s1_val   <= pt_rd.val;
    s2_p     <= scsc_pkg::qmul(keff[0], keff[1]);
    s2_k2    <= keff[2];
    s2_k3    <= keff[3];
    s2_stale <= s1_stale;
    s2_val   <= s1_val;
    s3_p     <= scsc_pkg::qmul(s2_p, s2_k2);
    s3_k3    <= s2_k3;
    s3_stale <= s2_stale;
    s3_val   <= s2_val;
    s4_p     <= s3_stale ? '0 : scsc_pkg::qmul(s3_p, s3_k3);
    s4_val   <= s3_val;
    s5_term  <= 41'($signed(s4_val)) * 41'($signed({1'b0, s4_p}));
  end

  assign acc_sh = acc >>> scsc_pkg::FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      n         <= '0;
      pv        <= '0;
      out_valid <= 1'b0;
    end else begin
      pv <= {pv[4:0], issue};
      if (issue) n <= n + CNT_W'(1);
      if (pv[5]) acc <= acc + ACC_W'(s5_term);
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid && q_ready) begin
            out_sum <= '0;
            out_lin <= '0;
            case (q_data.kind)
              scsc_pkg::K_BEYOND: begin
                out_status <= scsc_pkg::ST_BEYOND;
                out_valid  <= 1'b1;
              end
              scsc_pkg::K_PLOAD: begin
                out_valid <= 1'b1;
                if (32'(count) < MAX_POINTS) begin
                  out_status <= scsc_pkg::ST_OK;
                  count      <= count + CNT_W'(1);
                end else begin
                  out_status <= scsc_pkg::ST_FULL;
                end
              end
              scsc_pkg::K_CLEAR: begin
                out_status <= scsc_pkg::ST_OK;
                out_valid  <= 1'b1;
                count      <= '0;
              end
              scsc_pkg::K_EVAL: begin
                if (32'(q_data.point_number) >= 32'(count) ||
                    32'(q_data.point_number) >= MAX_POINTS) begin
                  out_status <= scsc_pkg::ST_NOTSTOR;
                  out_valid  <= 1'b1;
                end else begin
                  out_status <= scsc_pkg::ST_OK;
                  state      <= S_RDO;
                end
              end
              default: begin
                out_status <= scsc_pkg::ST_OK;
                out_valid  <= 1'b1;
              end
            endcase
          end
        end
        S_RDO: begin
          o_c <= pt_rd.c;
          if (stale_c) begin
            out_status <= scsc_pkg::ST_BEYOND;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end else begin
            state <= S_LIN1;
          end
        end
        S_LIN1: begin
          la    <= 13'(o_c[1]) * 13'(sizes[0]);
          s01   <= 14'(sizes[0]) * 14'(sizes[1]);
          state <= S_LIN2;
        end
        S_LIN2: begin
          lb    <= 20'(o_c[2]) * 20'(s01);
          s012  <= 21'(s01) * 21'(sizes[2]);
          state <= S_LIN3;
        end
        S_LIN3: begin
          lc    <= 27'(o_c[3]) * 27'(s012);
          acc   <= '0;
          n     <= '0;
          state <= S_LOOP;
        end
        S_LOOP: begin
          if (!issue && pv == '0) state <= S_FIN;
        end
        S_FIN: begin
          if (acc_sh > SMAX) out_sum <= SMAX[scsc_pkg::SUM_W-1:0];
          else if (acc_sh < SMIN) out_sum <= SMIN[scsc_pkg::SUM_W-1:0];
          else out_sum <= acc_sh[scsc_pkg::SUM_W-1:0];
          out_lin   <= 24'(28'(o_c[0]) + 28'(la) + 28'(lb) + 28'(lc));
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= MAX_POINTS) else $error("point count beyond store depth");
  a_pipe_in_loop: assert property (@(posedge clk) disable iff (rst)
    pv != '0 |-> state == S_LOOP) else $error("pipeline busy outside evaluation");
  a_sum_only_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != scsc_pkg::ST_OK |-> out_sum == '0 && out_lin == '0)
    else $error("nonzero result with error status");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !q_ready) else $error("queue popped while busy");
endmodule

FILE: sv/sparse_circular_separable_convolution.sv
// Top level of the sparse 4D circular convolution with separable kernel.
//
// The block takes command words on the s_ stream (kernel loads, point loads,
// clear, evaluate) and returns one result word on the m_ stream for each.
// A front end classifies each word against the current axis sizes and drops
// it into a two-word queue, so new words are taken while the engine works or
// a result waits. Kernel loads, point loads and clears are answered from the
// engine's idle state. An evaluate reads the named point, works out the
// linear index in states S_LIN1 to S_LIN3, and then streams every stored
// point through one multiply-accumulate pipeline at one point a cycle. Axis
// sizes are written through the cfg_ port and must only change while the
// block is idle. No clearing pass is needed after reset.
module sparse_circular_separable_convolution #(
  parameter int MAX_AXIS_LEN = scsc_pkg::MAX_AXIS_LEN_DEF,
  parameter int MAX_POINTS   = scsc_pkg::MAX_POINTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // axis, table_index, kernel_value, coord_i, coord_j, coord_k, coord_l,
  // sample_value, point_number, then zero fill
  input  logic [scsc_pkg::IN_DATA_W-1:0]    s_tdata,
  // command
  input  logic [1:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // sum_value, linear_index
  output logic [scsc_pkg::OUT_DATA_W-1:0]   m_tdata,
  // status
  output logic [1:0]                        m_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [scsc_pkg::SIZE_W-1:0]       cfg_data
);
  localparam int SIZE_RST_I = (64 > MAX_AXIS_LEN) ? MAX_AXIS_LEN : 64;
  localparam logic [scsc_pkg::SIZE_W-1:0] SIZE_RST = SIZE_RST_I[scsc_pkg::SIZE_W-1:0];

  scsc_pkg::sizes_t sizes;
  scsc_pkg::cmd_t   f_cmd, q_cmd;
  logic             q_valid, q_ready;
  logic [scsc_pkg::SUM_W-1:0] sum;
  logic [scsc_pkg::LIN_W-1:0] lin;

  assign cfg_ready = 1'b1;

  // Axis size registers, clamped to the legal range on write.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 4; a++) sizes[a] <= SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_data < 7'd2) sizes[cfg_index] <= 7'd2;
      else if (32'(cfg_data) > MAX_AXIS_LEN) sizes[cfg_index] <= 7'(MAX_AXIS_LEN);
      else sizes[cfg_index] <= cfg_data;
    end
  end

  scsc_front #(.MAX_AXIS_LEN(MAX_AXIS_LEN)) u_front (
    .tdata (s_tdata),
    .tuser (s_tuser),
    .sizes (sizes),
    .cmd   (f_cmd)
  );

  scsc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (f_cmd),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_cmd)
  );

  scsc_back #(.MAX_AXIS_LEN(MAX_AXIS_LEN), .MAX_POINTS(MAX_POINTS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .sizes      (sizes),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_data     (q_cmd),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (m_tuser),
    .out_sum    (sum),
    .out_lin    (lin)
  );

  assign m_tdata = {lin, sum};
endmodule

FILE: tb/tb_top.sv
// Self-checking testbench of the sparse circular separable convolution block.
module tb_top;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [1:0]        axis;
    logic [5:0]        tidx;
    logic [15:0]       kval;
    logic [3:0][5:0]   c;
    logic [23:0]       sval;
    logic [9:0]        pnum;
  } word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [39:0] sum;
    logic [23:0] lin;
  } result_t;

  localparam int TAB_LEN = scsc_pkg::MAX_AXIS_LEN_DEF / 2 + 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [scsc_pkg::IN_DATA_W-1:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [scsc_pkg::OUT_DATA_W-1:0] m_tdata;
  logic [1:0] m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [scsc_pkg::SIZE_W-1:0] cfg_data = '0;

  sparse_circular_separable_convolution u_dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // Predicted block state.
  int unsigned axis_len [4];
  logic [15:0] ktab [4][TAB_LEN];
  logic [5:0]  pt_coord [scsc_pkg::MAX_POINTS_DEF][4];
  longint      pt_val [scsc_pkg::MAX_POINTS_DEF];
  int unsigned pt_count;

  // Stimulus side view of sizes and count, used to aim evaluates.
  int unsigned gen_len [4];
  int unsigned gen_count;

  word_t   pending [$];
  result_t expected_results [$];
  int      errors = 0;
  int      send_idle = 0;
  int      recv_stall = 0;

  initial forever #5 clk = ~clk;

  initial begin
    #30_000_000;
    $display("sparse_circular_separable_convolution regression: fail");
    $finish;
  end

  function automatic logic [scsc_pkg::IN_DATA_W-1:0] pack_word(word_t w);
    logic [scsc_pkg::IN_DATA_W-1:0] d;
    d = '0;
    d[1:0] = w.axis;
    d[7:2] = w.tidx;
    d[23:8] = w.kval;
    d[29:24] = w.c[0];
    d[35:30] = w.c[1];
    d[41:36] = w.c[2];
    d[47:42] = w.c[3];
    d[71:48] = w.sval;
    d[81:72] = w.pnum;
    return d;
  endfunction

  function automatic logic [15:0] q_product(logic [15:0] a, logic [15:0] b);
    logic [31:0] p;
    p = (32'(a) * 32'(b)) >> 14;
    return (p > 32'hFFFF) ? 16'hFFFF : p[15:0];
  endfunction

  // Applies one command to the predicted state and returns its result word.
  function automatic result_t convolve_step(word_t w);
    result_t r;
    bit beyond;
    longint acc, res;
    int unsigned d, pn;
    logic [15:0] prod;
    bit stale;
    r = '0;
    case (w.cmd)
      scsc_pkg::CMD_KLOAD: begin
        if (w.tidx >= TAB_LEN) r.status = scsc_pkg::ST_BEYOND;
        else ktab[w.axis][w.tidx] = w.kval;
      end
      scsc_pkg::CMD_PLOAD: begin
        beyond = 0;
        for (int a = 0; a < 4; a++) if (w.c[a] >= axis_len[a]) beyond = 1;
        if (beyond) r.status = scsc_pkg::ST_BEYOND;
        else if (w.sval == 0) r.status = scsc_pkg::ST_OK;
        else if (pt_count >= scsc_pkg::MAX_POINTS_DEF) r.status = scsc_pkg::ST_FULL;
        else begin
          for (int a = 0; a < 4; a++) pt_coord[pt_count][a] = w.c[a];
          pt_val[pt_count] = longint'($signed(w.sval));
          pt_count++;
        end
      end
      scsc_pkg::CMD_CLEAR: pt_count = 0;
      default: begin
        pn = w.pnum;
        if (pn >= pt_count) r.status = scsc_pkg::ST_NOTSTOR;
        else begin
          beyond = 0;
          for (int a = 0; a < 4; a++) if (pt_coord[pn][a] >= axis_len[a]) beyond = 1;
          if (beyond) r.status = scsc_pkg::ST_BEYOND;
          else begin
            acc = 0;
            for (int n = 0; n < pt_count; n++) begin
              stale = 0;
              prod = '0;
              for (int a = 0; a < 4; a++) begin
                if (pt_coord[n][a] >= axis_len[a]) stale = 1;
                else begin
                  d = (pt_coord[pn][a] > pt_coord[n][a]) ? pt_coord[pn][a] - pt_coord[n][a]
                                                         : pt_coord[n][a] - pt_coord[pn][a];
                  if (d > axis_len[a] / 2) d = axis_len[a] - d;
                  if (d >= TAB_LEN) d = TAB_LEN - 1;
                  prod = (a == 0) ? ktab[0][d] : q_product(prod, ktab[a][d]);
                end
              end
              if (!stale) acc += pt_val[n] * longint'(prod);
            end
            // Arithmetic shift rounds toward minus infinity.
            res = acc >>> 14;
            if (res > 64'sd549755813887) res = 64'sd549755813887;
            if (res < -64'sd549755813888) res = -64'sd549755813888;
            r.sum = res[39:0];
            res = longint'(pt_coord[pn][0]) + longint'(pt_coord[pn][1]) * axis_len[0]
                + longint'(pt_coord[pn][2]) * axis_len[0] * axis_len[1]
                + longint'(pt_coord[pn][3]) * axis_len[0] * axis_len[1] * axis_len[2];
            r.lin = res[23:0];
          end
        end
      end
    endcase
    return r;
  endfunction

  // Driver: keeps a word on the bus until it is taken.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_results.insert(expected_results.size(),
          convolve_step(word_t'({s_tuser, s_tdata[1:0], s_tdata[7:2], s_tdata[23:8],
                                 s_tdata[47:24], s_tdata[71:48], s_tdata[81:72]})));
      end
      if (!s_tvalid || s_tready) begin
        if (pending.size() > 0 && $urandom_range(99) >= send_idle) begin
          word_t w;
          w = pending.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= pack_word(w);
          s_tuser <= w.cmd;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each result word with the oldest prediction.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result status=%0d data=%h", $time, m_tuser, m_tdata);
          errors++;
        end else begin
          result_t e;
          e = expected_results.pop_front();
          if (m_tuser !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, m_tuser);
            errors++;
          end
          if (m_tdata[39:0] !== e.sum) begin
            $display("%0t: sum expected %h actual %h", $time, e.sum, m_tdata[39:0]);
            errors++;
          end
          if (m_tdata[63:40] !== e.lin) begin
            $display("%0t: linear index expected %h actual %h", $time, e.lin,
                     m_tdata[63:40]);
            errors++;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic write_size(input logic [1:0] idx, input logic [6:0] raw);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= raw;
    do @(posedge clk); while (!cfg_ready);
    axis_len[idx] = (raw < 2) ? 2 : (raw > scsc_pkg::MAX_AXIS_LEN_DEF) ?
                    scsc_pkg::MAX_AXIS_LEN_DEF : raw;
    gen_len[idx] = axis_len[idx];
    cfg_valid <= 1'b0;
  endtask

  // Checks are made after the edge has settled so a word that the driver
  // has just taken from the queue is seen on the bus.
  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pending.size() != 0 || expected_results.size() != 0 || s_tvalid);
    repeat (30) @(posedge clk);
  endtask

  task automatic add_kload(input int ax, input int ti, input logic [15:0] kv);
    word_t w;
    w = word_t'({$urandom(), $urandom(), $urandom()});
    w.cmd = scsc_pkg::CMD_KLOAD; w.axis = 2'(ax); w.tidx = 6'(ti); w.kval = kv;
    pending.insert(pending.size(), w);
  endtask

  task automatic add_point(input logic [3:0][5:0] c, input logic [23:0] v);
    word_t w;
    bit ok;
    w = word_t'({$urandom(), $urandom(), $urandom()});
    w.cmd = scsc_pkg::CMD_PLOAD; w.c = c; w.sval = v;
    ok = (v != 0);
    for (int a = 0; a < 4; a++) if (c[a] >= gen_len[a]) ok = 0;
    if (ok && gen_count < scsc_pkg::MAX_POINTS_DEF) gen_count++;
    pending.insert(pending.size(), w);
  endtask

  task automatic add_eval(input int pn);
    word_t w;
    w = word_t'({$urandom(), $urandom(), $urandom()});
    w.cmd = scsc_pkg::CMD_EVAL; w.pnum = 10'(pn);
    pending.insert(pending.size(), w);
  endtask

  task automatic add_clear();
    word_t w;
    w = word_t'({$urandom(), $urandom(), $urandom()});
    w.cmd = scsc_pkg::CMD_CLEAR;
    gen_count = 0;
    pending.insert(pending.size(), w);
  endtask

  function automatic logic [3:0][5:0] pick_coords(int wide_pct);
    logic [3:0][5:0] c;
    for (int a = 0; a < 4; a++)
      c[a] = ($urandom_range(99) < wide_pct) ? 6'($urandom_range(63))
                                             : 6'($urandom_range(gen_len[a] - 1));
    return c;
  endfunction

  task automatic random_items(input int count);
    int sel;
    logic [23:0] v;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      if (sel < 25) begin
        add_kload($urandom_range(3), ($urandom_range(9) == 0) ? $urandom_range(63)
                  : $urandom_range(TAB_LEN - 1),
                  ($urandom_range(7) == 0) ? 16'hFFFF : 16'($urandom_range(16'h7FFF)));
      end else if (sel < 65) begin
        case ($urandom_range(9))
          0: v = 24'd0;
          1: v = 24'h7FFFFF;
          2: v = 24'h800000;
          3, 4: v = 24'($urandom());
          default: v = 24'($urandom_range(2000) - 1000);
        endcase
        add_point(pick_coords(10), v);
      end else if (sel < 93) begin
        if (gen_count > 0 && $urandom_range(9) != 0) add_eval($urandom_range(gen_count - 1));
        else add_eval($urandom_range(1023));
      end else if (sel < 96 || gen_count > 80) begin
        add_clear();
      end else begin
        add_eval($urandom_range(1023));
      end
    end
  endtask

  initial begin
    for (int a = 0; a < 4; a++) begin
      axis_len[a] = scsc_pkg::MAX_AXIS_LEN_DEF;
      gen_len[a] = scsc_pkg::MAX_AXIS_LEN_DEF;
      for (int t = 0; t < TAB_LEN; t++) ktab[a][t] = '0;
    end
    pt_count = 0;
    gen_count = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed opening: table extremes, point extremes and the ok, beyond and not-stored status codes.
    add_eval(0);
    add_kload(0, 0, 16'hFFFF);
    add_kload(1, 32, 16'h4000);
    add_kload(2, 33, 16'h1234);
    add_kload(3, 63, 16'hFFFF);
    for (int a = 1; a < 4; a++) add_kload(a, 0, 16'h4000);
    add_point({6'd0, 6'd0, 6'd0, 6'd0}, 24'h7FFFFF);
    add_point({6'd63, 6'd63, 6'd63, 6'd63}, 24'h800000);
    add_point({6'd32, 6'd0, 6'd0, 6'd0}, 24'h000001);
    add_point({6'd1, 6'd2, 6'd3, 6'd4}, 24'd0);
    add_eval(0);
    add_eval(1);
    add_eval(2);
    add_eval(3);
    add_eval(1023);
    add_kload(0, 32, 16'h0000);
    add_eval(2);
    add_clear();
    add_eval(0);
    add_point({6'd5, 6'd40, 6'd7, 6'd9}, 24'hFFFFFF);
    add_eval(0);
    wait_drained();

    for (int ph = 0; ph < 9; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 63; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 63; end
        default: begin send_idle = 10; recv_stall = 10; end
      endcase
      // Size changes without a clear leave stale points behind on purpose.
      for (int a = 0; a < 4; a++) begin
        case (ph)
          0: write_size(2'(a), 7'd127);
          1: write_size(2'(a), a[0] ? 7'd0 : 7'd1);
          2: write_size(2'(a), 7'd64);
          3: write_size(2'(a), 7'($urandom_range(2, 8)));
          4: write_size(2'(a), 7'(65 + a));
          default: write_size(2'(a), 7'($urandom_range(2, 64)));
        endcase
      end
      random_items(58);
      wait_drained();
    end

    add_clear();
    add_eval(0);
    wait_drained();

    if (errors == 0) begin
      $display("sparse_circular_separable_convolution regression: pass");
    end else begin
      $display("sparse_circular_separable_convolution regression: fail");
    end
    $finish;
  end

endmodule
